// File: rtl/chcg_pkg.sv
`default_nettype none

package chcg_pkg;

    // Default longest code length, as in a JPEG DHT segment
    localparam int MAX_CODE_LENGTH = 16;

    // Fixed field widths of the two channels
    localparam int SYM_W  = 8;
    localparam int CODE_W = 16;
    localparam int LEN_W  = 5;

    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Input mode code for a per-length count
    localparam logic MODE_COUNT = 1'b0;

    // Input request as it arrives
    typedef struct packed {
        logic             mode;
        logic [SYM_W-1:0] value;
    } chcg_in_t;

    // Result request
    typedef struct packed {
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  code_length;
        logic              error;
    } chcg_out_t;

    // Class of a queued request
    typedef enum logic {
        ITEM_COUNT,
        ITEM_SYMBOL
    } item_kind_t;

    // Queue entry passed from front to back
    typedef struct packed {
        item_kind_t       kind;
        logic [SYM_W-1:0] value;
    } q_item_t;

    // Back end sequencer states
    typedef enum logic {
        BK_IDLE,
        BK_SEARCH
    } back_state_t;

endpackage

`default_nettype wire

// File: rtl/chcg_front.sv
`default_nettype none

module chcg_front
    import chcg_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire chcg_in_t s_data,
    output logic          q_valid,
    input  wire logic     q_ready,
    output q_item_t       q_item
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [FILL_W-1:0] FULL = FILL_W'(QUEUE_DEPTH);

    q_item_t            q_mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    q_item_t            in_item;
    logic               push;
    logic               pop;

    // Classify the incoming request
    always_comb begin
        in_item.kind  = (s_data.mode == MODE_COUNT) ? ITEM_COUNT : ITEM_SYMBOL;
        in_item.value = s_data.value;
    end

    assign s_ready = (fill_reg != FULL);
    assign q_valid = (fill_reg != '0);
    assign q_item  = q_mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    // Advance pointers and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            fill_next = fill_reg + FILL_W'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Hold queued payload
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/chcg_back.sv
`default_nettype none

module chcg_back
    import chcg_pkg::*;
#(
    parameter int MAX_CODE_LENGTH = chcg_pkg::MAX_CODE_LENGTH
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    q_valid,
    output logic         q_ready,
    input  wire q_item_t q_item,
    output logic         m_valid,
    input  wire logic    m_ready,
    output chcg_out_t    m_data
);

    localparam int CNT_W = $clog2(MAX_CODE_LENGTH + 1);
    localparam int IDX_W = (MAX_CODE_LENGTH > 1) ? $clog2(MAX_CODE_LENGTH) : 1;
    localparam int NC_W  = MAX_CODE_LENGTH + 1;
    localparam logic [CNT_W-1:0] MAX_LEN   = CNT_W'(MAX_CODE_LENGTH);
    localparam logic [NC_W-1:0]  CODE_LIM  = {1'b1, {MAX_CODE_LENGTH{1'b0}}};

    back_state_t        state_reg, state_next;
    logic [SYM_W-1:0]   counts_reg [MAX_CODE_LENGTH];
    logic [SYM_W-1:0]   counts_next [MAX_CODE_LENGTH];
    logic [CNT_W-1:0]   counts_loaded_reg, counts_loaded_next;
    logic [CNT_W-1:0]   cur_len_reg, cur_len_next;
    logic [SYM_W-1:0]   remaining_reg, remaining_next;
    logic [NC_W-1:0]    next_code_reg, next_code_next;
    logic [SYM_W-1:0]   symbol_reg, symbol_next;
    logic               m_valid_reg, m_valid_next;
    chcg_out_t          m_data_reg, m_data_next;

    logic               skip;
    logic               out_free;
    logic               finish;
    logic               take;
    logic               new_table;
    logic               fits;
    logic [NC_W:0]      code_shl;
    logic [NC_W:0]      code_inc;
    logic [NC_W-1:0]    code_shl_sat;
    logic [NC_W-1:0]    code_inc_sat;
    logic [CODE_W+NC_W-1:0] code_wide;
    logic [LEN_W+CNT_W-1:0] len_wide;

    assign skip     = (remaining_reg == '0) && (cur_len_reg < MAX_LEN);
    assign out_free = !m_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid && q_item.kind == ITEM_SYMBOL) begin
                    state_next = BK_SEARCH;
                end
            end
            BK_SEARCH: begin
                if (!skip && out_free) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        q_ready = 1'b0;
        finish  = 1'b0;
        unique case (state_reg)
            BK_IDLE:   q_ready = 1'b1;
            BK_SEARCH: finish  = !skip && out_free;
            default: begin
                q_ready = 1'b0;
                finish  = 1'b0;
            end
        endcase
    end

    assign take = q_valid && q_ready;

    // Saturating code arithmetic and fit check
    always_comb begin
        code_shl     = {next_code_reg, 1'b0};
        code_inc     = {1'b0, next_code_reg} + (NC_W + 1)'(1);
        code_shl_sat = (code_shl > {1'b0, CODE_LIM}) ? CODE_LIM : code_shl[NC_W-1:0];
        code_inc_sat = (code_inc > {1'b0, CODE_LIM}) ? CODE_LIM : code_inc[NC_W-1:0];
        fits         = ((next_code_reg >> cur_len_reg) == '0);
        code_wide    = {{CODE_W{1'b0}}, next_code_reg};
        len_wide     = {{LEN_W{1'b0}}, cur_len_reg};
    end

    assign new_table = (counts_loaded_reg == '0) || (counts_loaded_reg >= MAX_LEN);

    // Table state update
    always_comb begin
        counts_next        = counts_reg;
        counts_loaded_next = counts_loaded_reg;
        cur_len_next       = cur_len_reg;
        remaining_next     = remaining_reg;
        next_code_next     = next_code_reg;
        symbol_next        = symbol_reg;

        if (take) begin
            if (q_item.kind == ITEM_COUNT) begin
                // Store a count, clearing the table first when a new one begins
                if (new_table) begin
                    for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
                        counts_next[i] = '0;
                    end
                    counts_next[0]     = q_item.value;
                    counts_loaded_next = CNT_W'(1);
                    cur_len_next       = '0;
                    remaining_next     = '0;
                    next_code_next     = '0;
                end else begin
                    counts_next[counts_loaded_reg[IDX_W-1:0]] = q_item.value;
                    counts_loaded_next = counts_loaded_reg + CNT_W'(1);
                end
            end else begin
                // Close the count phase and latch the symbol
                counts_loaded_next = MAX_LEN;
                symbol_next        = q_item.value;
            end
        end else if (state_reg == BK_SEARCH) begin
            if (skip) begin
                // Enter the next length
                cur_len_next   = cur_len_reg + CNT_W'(1);
                next_code_next = code_shl_sat;
                remaining_next = counts_reg[cur_len_reg[IDX_W-1:0]];
            end else if (finish && remaining_reg != '0) begin
                // Consume one code at this length
                remaining_next = remaining_reg - SYM_W'(1);
                next_code_next = code_inc_sat;
            end
        end
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (finish) begin
            m_valid_next            = 1'b1;
            m_data_next.symbol      = symbol_reg;
            m_data_next.code        = '0;
            m_data_next.code_length = '0;
            m_data_next.error       = 1'b1;
            if (remaining_reg != '0 && fits) begin
                m_data_next.code        = code_wide[CODE_W-1:0];
                m_data_next.code_length = len_wide[LEN_W-1:0];
                m_data_next.error       = 1'b0;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= BK_IDLE;
            counts_loaded_reg <= '0;
            cur_len_reg       <= '0;
            remaining_reg     <= '0;
            next_code_reg     <= '0;
            m_valid_reg       <= 1'b0;
            for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
                counts_reg[i] <= '0;
            end
        end else begin
            state_reg         <= state_next;
            counts_loaded_reg <= counts_loaded_next;
            cur_len_reg       <= cur_len_next;
            remaining_reg     <= remaining_next;
            next_code_reg     <= next_code_next;
            m_valid_reg       <= m_valid_next;
            counts_reg        <= counts_next;
        end
    end

    // Hold payload
    always_ff @(posedge aclk) begin
        symbol_reg <= symbol_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A search runs only after the count phase is closed
    a_search_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_SEARCH |-> counts_loaded_reg == MAX_LEN)
        else $error("search with count phase open");

    // An error result carries no code bits and no length
    a_error_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.error |-> m_data_reg.code == '0 && m_data_reg.code_length == '0)
        else $error("error result with code bits");

    // The running code never passes its saturation limit
    a_code_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        next_code_reg <= CODE_LIM)
        else $error("running code past limit");

    // A finished symbol always lands in the output register
    a_finish_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        finish |=> m_valid_reg && m_data_reg.symbol == $past(symbol_reg))
        else $error("finished symbol not presented");

endmodule

`default_nettype wire

// File: rtl/canonical_huffman_code_generator.sv
// Operation: a count request is stored in the count table as it is taken; a symbol request
//   starts a length search that skips 0 to MAX_CODE_LENGTH exhausted lengths.
// Throughput: set by the length-search sequencer, one length per cycle; a 2-entry queue
//   and an output register let input and output stall independently.
// Reset: synchronous active-low aresetn clears the count store, the code state,
//   the queue and the output valid.
`default_nettype none

module canonical_huffman_code_generator
    import chcg_pkg::*;
#(
    parameter int MAX_CODE_LENGTH = chcg_pkg::MAX_CODE_LENGTH
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire chcg_in_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output chcg_out_t      m_data
);

    logic    q_valid;
    logic    q_ready;
    q_item_t q_item;

    // Accept and classify requests
    chcg_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    // Build codes
    chcg_back #(
        .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire
